>>> hw/rtl/buddy_block_allocator_defines.svh
// Assertion macros used by the allocator datapath RTL.
// The enclosing module must provide signals named clk and rst_n.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("buddy allocator assertion failed");
`define BBA_NEVER(lbl, expr) \
    `BBA_ASSERT(lbl, !(expr))
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_NEVER(lbl, expr)
`endif
`endif

>>> hw/rtl/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int MAX_ORDER_DEF       = 10;
    localparam int MIN_BLOCK_BYTES_DEF = 4096;
    localparam int HEADER_BYTES        = 16;
    localparam logic [31:0] POOL_RESET = 32'd4194304;

    localparam int BYTES_W = 32;
    localparam int OFF_W   = 10;
    localparam int GORD_W  = 4;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CFG,
        OP_BUILD,
        OP_LATCH,
        OP_SIZE,
        OP_POP,
        OP_POP_LD,
        OP_SPLIT,
        OP_GRANT,
        OP_FAIL,
        OP_ORD_RD,
        OP_ORD_LD,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_MERGE,
        OP_PUSH_DONE
    } dp_op_t;

    // Which free-list count the datapath looks at this cycle.
    typedef enum logic [1:0] {
        SEL_ORD,
        SEL_FIND,
        SEL_SPLIT,
        SEL_POOL
    } cnt_sel_t;

    typedef struct packed {
        dp_op_t   op;
        cnt_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic off_bad;
        logic size_bad;
        logic no_block;
        logic split_more;
        logic ord_top;
        logic scan_empty;
        logic hit;
        logic shift_more;
        logic res_free;
    } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/bba_datapath.sv
`default_nettype none
module bba_datapath #(
    parameter int MAX_ORDER       = bba_pkg::MAX_ORDER_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bba_pkg::cmd_t                cmd,
    output bba_pkg::status_t                  status,
    input  wire logic                         req_type,
    input  wire logic [bba_pkg::BYTES_W-1:0]  req_bytes,
    input  wire logic [bba_pkg::OFF_W-1:0]    free_offset,
    input  wire logic [bba_pkg::BYTES_W-1:0]  pool_size_bytes,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              ok,
    output logic [bba_pkg::OFF_W-1:0]         granted_offset,
    output logic [bba_pkg::GORD_W-1:0]        granted_order
);

    localparam int BW     = MAX_ORDER;
    localparam int NBLK   = 1 << BW;
    localparam int NORD   = MAX_ORDER + 1;
    localparam int OW     = $clog2(NORD);
    localparam int CW     = BW + 1;
    localparam int EA     = OW + BW;
    localparam int EDEPTH = NORD * NBLK;
    localparam logic [OW-1:0] ORD_MAX = OW'(MAX_ORDER);

    logic [bba_pkg::BYTES_W-1:0] size_reg;
    logic                        type_reg;
    logic [bba_pkg::BYTES_W-1:0] bytes_reg;
    logic [bba_pkg::OFF_W-1:0]   off_reg;
    logic [BW-1:0]               blk_reg;
    logic [OW-1:0]               ord_reg;
    logic [OW-1:0]               lvl_reg;
    logic [CW-1:0]               pos_reg;
    logic                        size_bad_reg;
    logic [CW-1:0]               cnt_reg [NORD];
    logic [BW-1:0]               ent_mem [EDEPTH];
    logic [BW-1:0]               ent_rd_reg;
    logic [OW-1:0]               bo_mem [NBLK];
    logic [OW-1:0]               bo_rd_reg;
    logic                        out_valid_reg;
    logic                        ok_reg;
    logic [bba_pkg::OFF_W-1:0]   goff_reg;
    logic [bba_pkg::GORD_W-1:0]  gord_reg;

    logic [32:0]    need;
    logic [OW-1:0]  sord;
    logic           sfit;
    logic           size_bad_c;
    logic [OW-1:0]  pord;
    logic           pool_ok;
    logic [OW-1:0]  jc;
    logic           jfound;
    logic [OW-1:0]  sel_idx;
    logic [CW-1:0]  cnt_sel;
    logic           cnt_full;
    logic [BW-1:0]  buddy;
    logic [BW-1:0]  split_buddy;
    logic [31:0]    off_wide;
    logic [BW-1:0]  off_blk;
    logic           off_bad;
    logic [OW-1:0]  bo_clamped;
    logic [31:0]    blk_wide;
    logic [31:0]    ord_wide;

    logic           ent_we;
    logic [EA-1:0]  ent_waddr;
    logic [BW-1:0]  ent_wdata;
    logic           ent_re;
    logic [EA-1:0]  ent_raddr;
    logic           bo_we;
    logic [BW-1:0]  bo_waddr;
    logic [OW-1:0]  bo_wdata;
    logic           res_free;
    logic           res_load;

    // Smallest order whose block holds the request plus its header.
    always_comb
    begin
        need = {1'b0, bytes_reg} + 33'(bba_pkg::HEADER_BYTES);
        sord = '0;
        sfit = 1'b0;
        for (int k = MAX_ORDER; k >= 0; k--)
        begin
            if ((64'(MIN_BLOCK_BYTES) << k) >= 64'(need))
            begin
                sord = OW'(k);
                sfit = 1'b1;
            end
        end
        size_bad_c = (64'(bytes_reg) < 64'(MIN_BLOCK_BYTES)) || !sfit;
    end

    always_comb
    begin
        pord = '0;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if ((64'(MIN_BLOCK_BYTES) << (k + 1)) <= 64'(size_reg))
            begin
                pord = OW'(k + 1);
            end
        end
        pool_ok = 64'(size_reg) >= 64'(MIN_BLOCK_BYTES);
    end

    // Lowest non-empty list at or above the requested order.
    always_comb
    begin
        jc     = '0;
        jfound = 1'b0;
        for (int k = MAX_ORDER; k >= 0; k--)
        begin
            if ((OW'(k) >= ord_reg) && (cnt_reg[k] != '0))
            begin
                jc     = OW'(k);
                jfound = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            bba_pkg::SEL_FIND:  sel_idx = jc;
            bba_pkg::SEL_SPLIT: sel_idx = lvl_reg - OW'(1);
            bba_pkg::SEL_POOL:  sel_idx = pord;
            default:            sel_idx = ord_reg;
        endcase
    end

    assign cnt_sel     = cnt_reg[sel_idx];
    assign cnt_full    = cnt_sel[BW];
    assign buddy       = blk_reg ^ (BW'(1) << ord_reg);
    assign split_buddy = blk_reg ^ (BW'(1) << sel_idx);
    assign off_wide    = 32'(off_reg);
    assign off_blk     = off_wide[BW-1:0];
    assign off_bad     = off_wide >= (32'd1 << BW);
    assign bo_clamped  = (bo_rd_reg > ORD_MAX) ? ORD_MAX : bo_rd_reg;
    assign blk_wide    = 32'(blk_reg);
    assign ord_wide    = 32'(ord_reg);
    assign res_free    = !out_valid_reg || !out_stall;
    assign res_load    = (cmd.op == bba_pkg::OP_GRANT) || (cmd.op == bba_pkg::OP_FAIL)
                      || (cmd.op == bba_pkg::OP_PUSH_DONE);

    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = {ord_reg, pos_reg[BW-1:0]};
        ent_wdata = blk_reg;
        ent_re    = 1'b0;
        ent_raddr = {ord_reg, pos_reg[BW-1:0]};
        bo_we     = 1'b0;
        bo_waddr  = blk_reg;
        bo_wdata  = ord_reg;
        case (cmd.op)
            bba_pkg::OP_BUILD:
            begin
                ent_we    = pool_ok;
                ent_waddr = {pord, BW'(0)};
                ent_wdata = '0;
                bo_we     = pool_ok;
                bo_waddr  = '0;
                bo_wdata  = pord;
            end
            bba_pkg::OP_POP:
            begin
                ent_re    = 1'b1;
                ent_raddr = {sel_idx, BW'(cnt_sel - CW'(1))};
            end
            bba_pkg::OP_SPLIT:
            begin
                ent_we    = !cnt_full;
                ent_waddr = {sel_idx, cnt_sel[BW-1:0]};
                ent_wdata = split_buddy;
                bo_we     = 1'b1;
                bo_waddr  = split_buddy;
                bo_wdata  = sel_idx;
            end
            bba_pkg::OP_GRANT:
            begin
                bo_we = 1'b1;
            end
            bba_pkg::OP_SCAN_RD:
            begin
                ent_re    = 1'b1;
                ent_raddr = {ord_reg, BW'(pos_reg - CW'(1))};
            end
            bba_pkg::OP_SHIFT_RD:
            begin
                ent_re    = 1'b1;
                ent_raddr = {ord_reg, BW'(pos_reg + CW'(1))};
            end
            bba_pkg::OP_SHIFT_WR:
            begin
                ent_we    = 1'b1;
                ent_wdata = ent_rd_reg;
            end
            bba_pkg::OP_PUSH_DONE:
            begin
                ent_we    = !cnt_full;
                ent_waddr = {ord_reg, cnt_sel[BW-1:0]};
                bo_we     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rd_reg <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bo_we)
        begin
            bo_mem[bo_waddr] <= bo_wdata;
        end
        if (cmd.op == bba_pkg::OP_ORD_RD)
        begin
            bo_rd_reg <= bo_mem[off_blk];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NORD; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            case (cmd.op) inside
                bba_pkg::OP_BUILD:
                begin
                    for (int k = 0; k < NORD; k++)
                    begin
                        cnt_reg[k] <= '0;
                    end
                    if (pool_ok)
                    begin
                        cnt_reg[pord] <= CW'(1);
                    end
                end
                bba_pkg::OP_POP, bba_pkg::OP_MERGE:
                begin
                    cnt_reg[sel_idx] <= cnt_sel - CW'(1);
                end
                bba_pkg::OP_SPLIT, bba_pkg::OP_PUSH_DONE:
                begin
                    if (!cnt_full)
                    begin
                        cnt_reg[sel_idx] <= cnt_sel + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= bba_pkg::POOL_RESET;
        end
        else if (cmd.op == bba_pkg::OP_CFG)
        begin
            size_reg <= pool_size_bytes;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bba_pkg::OP_LATCH:
            begin
                type_reg  <= req_type;
                bytes_reg <= req_bytes;
                off_reg   <= free_offset;
            end
            bba_pkg::OP_SIZE:
            begin
                ord_reg      <= sord;
                size_bad_reg <= size_bad_c;
            end
            bba_pkg::OP_POP:       lvl_reg <= sel_idx;
            bba_pkg::OP_POP_LD:    blk_reg <= ent_rd_reg;
            bba_pkg::OP_SPLIT:     lvl_reg <= sel_idx;
            bba_pkg::OP_ORD_RD:    blk_reg <= off_blk;
            bba_pkg::OP_ORD_LD:    ord_reg <= bo_clamped;
            bba_pkg::OP_SCAN_INIT: pos_reg <= cnt_sel;
            bba_pkg::OP_SCAN_RD:   pos_reg <= pos_reg - CW'(1);
            bba_pkg::OP_SHIFT_WR:  pos_reg <= pos_reg + CW'(1);
            bba_pkg::OP_MERGE:
            begin
                blk_reg <= blk_reg & ~(BW'(1) << ord_reg);
                ord_reg <= ord_reg + OW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ok_reg   <= (cmd.op != bba_pkg::OP_FAIL);
            goff_reg <= (cmd.op == bba_pkg::OP_GRANT) ? blk_wide[bba_pkg::OFF_W-1:0] : '0;
            gord_reg <= (cmd.op == bba_pkg::OP_GRANT) ? ord_wide[bba_pkg::GORD_W-1:0] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign granted_offset = goff_reg;
    assign granted_order  = gord_reg;

    always_comb
    begin
        status.is_free    = type_reg;
        status.off_bad    = off_bad;
        status.size_bad   = size_bad_reg;
        status.no_block   = !jfound;
        status.split_more = lvl_reg > ord_reg;
        status.ord_top    = ord_reg == ORD_MAX;
        status.scan_empty = pos_reg == '0;
        status.hit        = ent_rd_reg == buddy;
        status.shift_more = ({1'b0, pos_reg} + (CW + 1)'(1)) < {1'b0, cnt_sel};
        status.res_free   = res_free;
    end

`include "buddy_block_allocator_defines.svh"

    `BBA_ASSERT(a_load_when_free, res_load |-> res_free)
    `BBA_ASSERT(a_split_above_target, (cmd.op == bba_pkg::OP_SPLIT) |-> (lvl_reg > ord_reg))
    `BBA_ASSERT(a_shift_in_list, (cmd.op == bba_pkg::OP_SHIFT_RD) |-> status.shift_more)
    `BBA_ASSERT(a_valid_rise_loaded, $rose(out_valid_reg) |-> $past(res_load))
    `BBA_NEVER(a_pop_nonempty, (cmd.op == bba_pkg::OP_POP) && (cnt_sel == '0))

endmodule
`default_nettype wire

>>> hw/rtl/bba_ctrl.sv
`default_nettype none
module bba_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire bba_pkg::status_t status,
    output bba_pkg::cmd_t         cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_BUILD    = 15'h0002,
        S_DECODE   = 15'h0004,
        S_FIND     = 15'h0008,
        S_POP_LD   = 15'h0010,
        S_SPLIT    = 15'h0020,
        S_GRANT    = 15'h0040,
        S_FAIL     = 15'h0080,
        S_ORD_LD   = 15'h0100,
        S_CHECK    = 15'h0200,
        S_SCAN     = 15'h0400,
        S_SCAN_CMP = 15'h0800,
        S_SHIFT    = 15'h1000,
        S_SHIFT_WR = 15'h2000,
        S_PUSH     = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BUILD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bba_pkg::OP_NOP;
        cmd.sel    = bba_pkg::SEL_ORD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.op     = bba_pkg::OP_CFG;
                    state_next = S_BUILD;
                end
                else if (in_valid)
                begin
                    cmd.op     = bba_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_BUILD:
            begin
                cmd.op     = bba_pkg::OP_BUILD;
                cmd.sel    = bba_pkg::SEL_POOL;
                state_next = S_IDLE;
            end
            S_DECODE:
            begin
                if (!status.is_free)
                begin
                    cmd.op     = bba_pkg::OP_SIZE;
                    state_next = S_FIND;
                end
                else if (status.off_bad)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_ORD_RD;
                    state_next = S_ORD_LD;
                end
            end
            S_FIND:
            begin
                cmd.sel = bba_pkg::SEL_FIND;
                if (status.size_bad || status.no_block)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_POP;
                    state_next = S_POP_LD;
                end
            end
            S_POP_LD:
            begin
                cmd.op     = bba_pkg::OP_POP_LD;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.sel = bba_pkg::SEL_SPLIT;
                if (status.split_more)
                begin
                    cmd.op = bba_pkg::OP_SPLIT;
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end
            S_GRANT:
            begin
                if (status.res_free)
                begin
                    cmd.op     = bba_pkg::OP_GRANT;
                    state_next = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (status.res_free)
                begin
                    cmd.op     = bba_pkg::OP_FAIL;
                    state_next = S_IDLE;
                end
            end
            S_ORD_LD:
            begin
                cmd.op     = bba_pkg::OP_ORD_LD;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.ord_top)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_SCAN_INIT;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_empty)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_SCAN_RD;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                state_next = status.hit ? S_SHIFT : S_SCAN;
            end
            S_SHIFT:
            begin
                // Close the gap left by the buddy, then merge one level up.
                if (status.shift_more)
                begin
                    cmd.op     = bba_pkg::OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_MERGE;
                    state_next = S_CHECK;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.op     = bba_pkg::OP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_PUSH:
            begin
                if (status.res_free)
                begin
                    cmd.op     = bba_pkg::OP_PUSH_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_ready = state_reg == S_IDLE;
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;

endmodule
`default_nettype wire

>>> hw/rtl/buddy_block_allocator.sv
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   req_type, req_bytes, free_offset
// out       source     out_valid / out_stall ok, granted_offset, granted_order
// cfg       sink       cfg_valid / cfg_ready pool_size_bytes
//
// One item is worked at a time by a controller sequencing the free-list memory.
// An allocation pops the lowest fitting free block and splits it down to the requested order;
// a free merges with its buddy per level until none is found or the top order is reached.
// After reset, and after every cfg write, the build state rebuilds the free lists.
// A finished result sits in the output register, so the next item may start
// while out_stall holds the previous one.
`default_nettype none
module buddy_block_allocator #(
    parameter int MAX_ORDER       = bba_pkg::MAX_ORDER_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        req_type,
    input  wire logic [bba_pkg::BYTES_W-1:0] req_bytes,
    input  wire logic [bba_pkg::OFF_W-1:0]   free_offset,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             ok,
    output logic [bba_pkg::OFF_W-1:0]        granted_offset,
    output logic [bba_pkg::GORD_W-1:0]       granted_order,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bba_pkg::BYTES_W-1:0] pool_size_bytes
);

    bba_pkg::cmd_t    cmd;
    bba_pkg::status_t status;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bba_datapath #(
        .MAX_ORDER       (MAX_ORDER),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_type        (req_type),
        .req_bytes       (req_bytes),
        .free_offset     (free_offset),
        .pool_size_bytes (pool_size_bytes),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .granted_offset  (granted_offset),
        .granted_order   (granted_order)
    );

endmodule
`default_nettype wire
